### hw/rtl/spimp_pkg.sv
// Shared types, register codes and the prescaler table of the SPI master peripheral.
// No dependencies; imported by spimp_core and spi_master_peripheral.
package spimp_pkg;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_ACK   = 2'd3
    } t_cmd;

    localparam logic [2:0] OFF_CTRLA    = 3'd0;
    localparam logic [2:0] OFF_CTRLB    = 3'd1;
    localparam logic [2:0] OFF_INTCTRL  = 3'd2;
    localparam logic [2:0] OFF_INTFLAGS = 3'd3;
    localparam logic [2:0] OFF_DATA     = 3'd4;

    // control A bits
    localparam int CA_ENABLE = 0;
    localparam int CA_CPOL   = 4;
    localparam int CA_MASTER = 5;
    localparam int CA_DOUBLE = 7;
    // interrupt control and flag bits
    localparam int IE_BIT    = 0;
    localparam int WRCOL_BIT = 6;
    localparam int IF_BIT    = 7;
    // pin level vector
    localparam int PIN_MOSI = 0;
    localparam int PIN_SCK  = 1;
    localparam int PIN_SS   = 2;

    localparam int LEN_W = 11;

    typedef struct packed {
        logic       drive;
        logic       ss;
        logic       sck;
        logic       mosi;
        logic       ack;
        logic       irq;
        logic [7:0] read_value;
    } t_result;

    // log2 of the bit period for a prescaler select; divisors 4,16,64,128,2,8,32,4
    function automatic logic [2:0] f_period_shift(input logic [2:0] sel, input logic dbl);
        logic [2:0] sh;
        case (sel)
            3'd0:    sh = 3'd2;
            3'd1:    sh = 3'd4;
            3'd2:    sh = 3'd6;
            3'd3:    sh = 3'd7;
            3'd4:    sh = 3'd1;
            3'd5:    sh = 3'd3;
            3'd6:    sh = 3'd5;
            default: sh = 3'd2;
        endcase
        return dbl ? 3'(sh - 3'd1) : sh;
    endfunction

endpackage

### hw/rtl/spimp_core.sv
// Register set, transmit buffer, shifter and pin logic of the SPI master peripheral.
// Applies one item per enabled cycle; depends on spimp_pkg.
module spimp_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  logic [1:0]        i_cmd,
    input  logic [2:0]        i_reg_offset,
    input  logic [7:0]        i_write_value,
    output spimp_pkg::t_result o_result
);
    import spimp_pkg::*;

    logic [7:0]       r_ctrla, r_ctrlb, r_intctrl, r_intflags, r_rx, r_tx, r_shifter;
    logic [7:0]       n_ctrla, n_ctrlb, n_intctrl, n_intflags, n_rx, n_tx, n_shifter;
    logic             r_hf, r_busy, r_drive;
    logic             n_hf, n_busy, n_drive;
    logic [LEN_W-1:0] r_elapsed, r_len;
    logic [LEN_W-1:0] n_elapsed, n_len;
    logic [2:0]       r_shift, n_shift;
    logic [2:0]       r_pins, n_pins;

    always_comb begin
        logic [LEN_W-1:0] e;
        logic [LEN_W-1:0] idx_full;
        logic [2:0]       idx;
        logic             sck;
        logic [7:0]       rd;
        logic             ack;

        n_ctrla    = r_ctrla;
        n_ctrlb    = r_ctrlb;
        n_intctrl  = r_intctrl;
        n_intflags = r_intflags;
        n_rx       = r_rx;
        n_tx       = r_tx;
        n_shifter  = r_shifter;
        n_hf       = r_hf;
        n_busy     = r_busy;
        n_drive    = r_drive;
        n_elapsed  = r_elapsed;
        n_len      = r_len;
        n_shift    = r_shift;
        n_pins     = r_pins;
        rd         = 8'd0;
        ack        = 1'b0;

        e        = LEN_W'(r_elapsed + 1'b1);
        idx_full = e >> r_shift;
        idx      = (idx_full > LEN_W'(7)) ? 3'd7 : idx_full[2:0];
        sck      = (r_shift != 3'd0) && !e[3'(r_shift - 3'd1)];

        case (t_cmd'(i_cmd))
            CMD_TICK: begin
                if (r_ctrla[CA_ENABLE]) begin
                    if (r_busy) begin
                        n_elapsed = e;
                        if (r_ctrla[CA_MASTER]) begin
                            n_pins[PIN_MOSI] = r_shifter[3'd7 - idx];
                            n_pins[PIN_SCK]  = sck ^ r_ctrla[CA_CPOL];
                            n_pins[PIN_SS]   = 1'b0;
                        end
                        if (e >= r_len) begin
                            n_busy             = 1'b0;
                            n_intflags[IF_BIT] = 1'b1;
                            if (r_ctrla[CA_MASTER]) n_pins[PIN_SS] = 1'b1;
                            n_rx = r_shifter;
                            if (r_hf) begin
                                n_shifter = r_tx;
                                n_hf      = 1'b0;
                                n_busy    = 1'b1;
                                n_elapsed = '0;
                            end
                        end
                    end else if (r_hf) begin
                        n_shifter = r_tx;
                        n_hf      = 1'b0;
                        n_busy    = 1'b1;
                        n_elapsed = '0;
                    end
                end
            end
            CMD_READ: begin
                case (i_reg_offset)
                    OFF_CTRLA:    rd = r_ctrla;
                    OFF_CTRLB:    rd = r_ctrlb;
                    OFF_INTCTRL:  rd = r_intctrl;
                    OFF_INTFLAGS: rd = r_intflags;
                    OFF_DATA: begin
                        rd                 = r_rx;
                        n_intflags[IF_BIT] = 1'b0;
                    end
                    default:      rd = 8'd0;
                endcase
            end
            CMD_WRITE: begin
                case (i_reg_offset)
                    OFF_CTRLA: begin
                        n_ctrla = i_write_value;
                        if (!i_write_value[CA_ENABLE]) begin
                            n_pins  = 3'b111;
                            n_drive = 1'b0;
                        end else if (!r_ctrla[CA_ENABLE]) begin
                            n_pins[PIN_MOSI] = 1'b1;
                            n_pins[PIN_SCK]  = i_write_value[CA_CPOL];
                            n_drive          = i_write_value[CA_MASTER];
                            if (i_write_value[CA_MASTER]) n_pins[PIN_SS] = 1'b1;
                        end
                    end
                    OFF_CTRLB:   n_ctrlb   = i_write_value;
                    OFF_INTCTRL: n_intctrl = i_write_value;
                    OFF_INTFLAGS: begin
                        if (i_write_value[IF_BIT]) n_intflags[IF_BIT] = 1'b0;
                    end
                    OFF_DATA: begin
                        if (r_ctrla[CA_ENABLE]) begin
                            if (r_hf) begin
                                n_intflags[WRCOL_BIT] = 1'b1;
                            end else begin
                                n_tx               = i_write_value;
                                n_hf               = 1'b1;
                                n_intflags[IF_BIT] = 1'b0;
                                if (!r_busy) begin
                                    n_shifter = i_write_value;
                                    n_hf      = 1'b0;
                                    n_busy    = 1'b1;
                                    n_elapsed = '0;
                                end
                                n_shift = f_period_shift(r_ctrla[3:1], r_ctrla[CA_DOUBLE]);
                                n_len   = LEN_W'(1) << (4'(n_shift) + 4'd3);
                            end
                        end
                    end
                    default: ;
                endcase
            end
            CMD_ACK: begin
                if (r_intflags[IF_BIT] && r_intctrl[IE_BIT]) begin
                    n_intflags[IF_BIT] = 1'b0;
                    ack                = 1'b1;
                end
            end
            default: ;
        endcase

        o_result.read_value = rd;
        o_result.irq        = n_intflags[IF_BIT] & n_intctrl[IE_BIT];
        o_result.ack        = ack;
        o_result.mosi       = n_pins[PIN_MOSI];
        o_result.sck        = n_pins[PIN_SCK];
        o_result.ss         = n_pins[PIN_SS];
        o_result.drive      = n_drive;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrla    <= 8'd0;
            r_ctrlb    <= 8'd0;
            r_intctrl  <= 8'd0;
            r_intflags <= 8'd0;
            r_rx       <= 8'd0;
            r_tx       <= 8'd0;
            r_shifter  <= 8'd0;
            r_hf       <= 1'b0;
            r_busy     <= 1'b0;
            r_drive    <= 1'b0;
            r_elapsed  <= '0;
            r_len      <= '0;
            r_shift    <= 3'd0;
            r_pins     <= 3'b111;
        end else if (i_advance) begin
            r_ctrla    <= n_ctrla;
            r_ctrlb    <= n_ctrlb;
            r_intctrl  <= n_intctrl;
            r_intflags <= n_intflags;
            r_rx       <= n_rx;
            r_tx       <= n_tx;
            r_shifter  <= n_shifter;
            r_hf       <= n_hf;
            r_busy     <= n_busy;
            r_drive    <= n_drive;
            r_elapsed  <= n_elapsed;
            r_len      <= n_len;
            r_shift    <= n_shift;
            r_pins     <= n_pins;
        end
    end

`ifndef SYNTH
    a_busy_has_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_len != '0))
        else $error("shifter busy with zero transfer length");
    a_buffer_needs_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hf |-> r_busy)
        else $error("transmit buffer full while shifter idle");
    a_drive_needs_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drive |-> r_ctrla[CA_ENABLE])
        else $error("pins driven while disabled");
    a_ack_clears_irq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && o_result.ack) |-> !o_result.irq)
        else $error("acknowledge left interrupt pending");
`endif

endmodule

### hw/rtl/spi_master_peripheral.sv
// Top level of the SPI master peripheral: input register, core and output register.
// Depends on spimp_pkg and spimp_core.
//
// Usage: every item (tick, bus read, bus write, interrupt acknowledge) is one
// transfer on the slave stream and yields exactly one result transfer on the
// master stream. One item is accepted per clock while the master side takes results;
// back pressure on the master side stalls both registers. Each result passes through
// the input register, then the core's update of the register set into the output
// register.
module spi_master_peripheral (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [2:0] reg_offset, [10:3] write_value, rest zero
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] cmd
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata    // [7:0] read_value, [8] irq, [9] ack_taken,
                                          // [10] mosi_level, [11] sck_level,
                                          // [12] ss_level, [13] pins_driven, rest zero
);
    import spimp_pkg::*;

    logic       r_in_valid;
    logic [1:0] r_cmd;
    logic [2:0] r_off;
    logic [7:0] r_val;
    logic       r_out_valid;
    t_result    r_out;
    t_result    core_result;
    logic       advance;
    logic       in_xfer;

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cmd <= i_s_axis_tuser;
            r_off <= i_s_axis_tdata[2:0];
            r_val <= i_s_axis_tdata[10:3];
        end
    end

    spimp_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_cmd        (r_cmd),
        .i_reg_offset (r_off),
        .i_write_value(r_val),
        .o_result     (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // hold the result until the master side takes it
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out};

endmodule

### sim/tb_spi_master_peripheral.sv
// Self-checking testbench for spi_master_peripheral: bus, tick and acknowledge items in,
// one checked result per item out, with a cycle-accurate predictor of the register set.
// Depends on spimp_pkg and the spi_master_peripheral RTL.
`timescale 1ns / 1ps

module tb_spi_master_peripheral;
    import spimp_pkg::*;

    localparam int CLK_HALF_NS     = 10;
    localparam int RESET_CYCLES    = 3;
    localparam int RANDOM_ITEMS    = 1580;
    localparam int HOLD_CYCLES     = 120;
    localparam int DRAIN_LIMIT     = 5000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int TIMEOUT_NS      = 20_000_000;
    localparam int MAX_REPORTS     = 10;
    localparam int TICK_GUARD      = 2400;
    localparam logic [2:0] OFF_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] OFF_UNUSED_LAST  = 3'd7;

    logic        i_clk;
    logic        i_rst_n          = 1'b0;
    logic        i_s_axis_tvalid  = 1'b0;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata   = '0;  // [2:0] reg_offset, [10:3] write_value, rest zero
    logic [1:0]  i_s_axis_tuser   = '0;  // [1:0] cmd
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready  = 1'b0;
    logic [15:0] o_m_axis_tdata;         // [7:0] read_value, [8] irq, [9] ack_taken,
                                         // [10] mosi, [11] sck, [12] ss, [13] pins_driven

    spi_master_peripheral DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // predicted register set, at its reset values
    logic [7:0]  ctrl_a    = '0;
    logic [7:0]  ctrl_b    = '0;
    logic [7:0]  int_ctl   = '0;
    logic [7:0]  int_flg   = '0;
    logic [7:0]  rx_byte   = '0;
    logic [7:0]  tx_hold   = '0;
    logic [7:0]  shift_reg = '0;
    logic        hold_full = 1'b0;
    logic        busy_q    = 1'b0;
    logic        drive_q   = 1'b0;
    logic [10:0] elapsed   = '0;
    logic [10:0] xfer_len  = '0;
    logic [2:0]  pins      = 3'b111;

    t_result expected_results[$];

    int items_sent      = 0;
    int results_checked = 0;
    int mismatch_count  = 0;
    int orphan_count    = 0;
    int transfers_done  = 0;
    int collisions      = 0;
    bit idle_off        = 1'b0;
    bit hold_pending    = 1'b0;
    bit hold_active     = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF_NS) i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Run exceeded its time limit with %0d results outstanding",
                 expected_results.size());
        $display("tb_spi_master_peripheral failed");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] make_ctrla(input logic en, input logic master,
                                              input logic cpol, input logic [2:0] sel,
                                              input logic dbl);
        logic [7:0] v;
        v = '0;
        v[CA_ENABLE] = en;
        v[CA_MASTER] = master;
        v[CA_CPOL]   = cpol;
        v[3:1]       = sel;
        v[CA_DOUBLE] = dbl;
        return v;
    endfunction

    function automatic void load_shifter();
        shift_reg = tx_hold;
        hold_full = 1'b0;
        busy_q    = 1'b1;
        elapsed   = '0;
    endfunction

    // Advance the predicted register set by one item and return its result.
    function automatic t_result predict_item(input t_cmd cmd, input logic [2:0] off,
                                             input logic [7:0] val);
        t_result    r;
        int         bd;
        int         idx;
        int         div;
        logic       sck;
        logic [7:0] old_a;
        r = '0;
        case (cmd)
            CMD_TICK: begin
                if (ctrl_a[CA_ENABLE]) begin
                    if (busy_q) begin
                        elapsed = elapsed + 11'd1;
                        if (ctrl_a[CA_MASTER]) begin
                            bd = int'(xfer_len) / 8;
                            if (bd == 0) bd = 1;
                            idx = int'(elapsed) / bd;
                            if (idx > 7) idx = 7;
                            pins[PIN_MOSI] = shift_reg[7 - idx];
                            sck = (int'(elapsed) % bd) < (bd / 2);
                            if (ctrl_a[CA_CPOL]) sck = ~sck;
                            pins[PIN_SCK] = sck;
                            pins[PIN_SS]  = 1'b0;
                        end
                        if (elapsed >= xfer_len) begin
                            busy_q = 1'b0;
                            int_flg[IF_BIT] = 1'b1;
                            if (ctrl_a[CA_MASTER]) pins[PIN_SS] = 1'b1;
                            rx_byte = shift_reg;
                            transfers_done++;
                            if (hold_full) load_shifter();
                        end
                    end else if (hold_full) begin
                        load_shifter();
                    end
                end
            end
            CMD_READ: begin
                case (off)
                    OFF_CTRLA:    r.read_value = ctrl_a;
                    OFF_CTRLB:    r.read_value = ctrl_b;
                    OFF_INTCTRL:  r.read_value = int_ctl;
                    OFF_INTFLAGS: r.read_value = int_flg;
                    OFF_DATA: begin
                        int_flg[IF_BIT] = 1'b0;
                        r.read_value = rx_byte;
                    end
                    default:      r.read_value = '0;
                endcase
            end
            CMD_WRITE: begin
                case (off)
                    OFF_CTRLA: begin
                        old_a  = ctrl_a;
                        ctrl_a = val;
                        if (!val[CA_ENABLE]) begin
                            pins    = 3'b111;
                            drive_q = 1'b0;
                        end else if (!old_a[CA_ENABLE]) begin
                            pins[PIN_MOSI] = 1'b1;
                            pins[PIN_SCK]  = val[CA_CPOL];
                            drive_q = val[CA_MASTER];
                            if (val[CA_MASTER]) pins[PIN_SS] = 1'b1;
                        end
                    end
                    OFF_CTRLB:    ctrl_b  = val;
                    OFF_INTCTRL:  int_ctl = val;
                    OFF_INTFLAGS: if (val[IF_BIT]) int_flg[IF_BIT] = 1'b0;
                    OFF_DATA: begin
                        if (ctrl_a[CA_ENABLE]) begin
                            if (hold_full) begin
                                int_flg[WRCOL_BIT] = 1'b1;
                                collisions++;
                            end else begin
                                tx_hold   = val;
                                hold_full = 1'b1;
                                int_flg[IF_BIT] = 1'b0;
                                if (!busy_q) load_shifter();
                                case (ctrl_a[3:1])
                                    3'd0: div = 4;
                                    3'd1: div = 16;
                                    3'd2: div = 64;
                                    3'd3: div = 128;
                                    3'd4: div = 2;
                                    3'd5: div = 8;
                                    3'd6: div = 32;
                                    default: div = 4;
                                endcase
                                if (ctrl_a[CA_DOUBLE]) div = div / 2;
                                xfer_len = 11'(div * 8);
                            end
                        end
                    end
                    default: ;
                endcase
            end
            default: begin
                if (int_flg[IF_BIT] && int_ctl[IE_BIT]) begin
                    int_flg[IF_BIT] = 1'b0;
                    r.ack = 1'b1;
                end
            end
        endcase
        r.irq   = int_flg[IF_BIT] & int_ctl[IE_BIT];
        r.mosi  = pins[PIN_MOSI];
        r.sck   = pins[PIN_SCK];
        r.ss    = pins[PIN_SS];
        r.drive = drive_q;
        return r;
    endfunction

    // Offer one item, hold it until the transfer, then record its expected result.
    task automatic send_item(input t_cmd cmd, input logic [2:0] off, input logic [7:0] val);
        int gap;
        gap = idle_off ? 0 : pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= cmd;
        i_s_axis_tdata  <= {5'b0, val, off};
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        expected_results.insert(expected_results.size(), predict_item(cmd, off, val));
        items_sent++;
    endtask

    task automatic send_tick();
        send_item(CMD_TICK, 3'($urandom_range(0, 7)), 8'($urandom));
    endtask

    // Tick until the shifter and the buffer are empty; optionally mix in bus traffic.
    task automatic run_ticks(input bit mix);
        int guard;
        int r;
        guard = 0;
        while (ctrl_a[CA_ENABLE] && (busy_q || hold_full) && guard < TICK_GUARD) begin
            r = mix ? $urandom_range(0, 99) : 99;
            if (r < 6)
                send_item(CMD_READ, 3'($urandom_range(0, 7)), 8'($urandom));
            else if (r < 9)
                send_item(CMD_ACK, 3'($urandom_range(0, 7)), 8'($urandom));
            else if (r < 11)
                send_item(CMD_WRITE, OFF_DATA, 8'($urandom));
            else if (r < 12)
                send_item(CMD_WRITE, OFF_INTFLAGS, 8'($urandom));
            else if (r < 13)
                send_item(CMD_WRITE, OFF_CTRLA, 8'($urandom));
            else
                send_tick();
            guard++;
        end
        repeat ($urandom_range(0, 3)) send_tick();
    endtask

    task automatic test_reset_state();
        for (int off = 0; off <= int'(OFF_UNUSED_LAST); off++)
            send_item(CMD_READ, 3'(off), 8'h00);
        send_item(CMD_TICK, OFF_UNUSED_LAST, 8'hFF);
        // disabled block ignores data writes
        send_item(CMD_WRITE, OFF_DATA, 8'hFF);
        send_item(CMD_ACK, OFF_CTRLA, 8'h00);
    endtask

    task automatic test_register_access();
        send_item(CMD_WRITE, OFF_CTRLB, 8'hFF);
        send_item(CMD_READ, OFF_CTRLB, 8'h00);
        send_item(CMD_WRITE, OFF_INTCTRL, 8'hFF);
        send_item(CMD_READ, OFF_INTCTRL, 8'h00);
        send_item(CMD_WRITE, OFF_UNUSED_LAST, 8'hFF);
        send_item(CMD_READ, OFF_UNUSED_FIRST, 8'h00);
        send_item(CMD_WRITE, OFF_INTFLAGS, 8'hFF);
        send_item(CMD_WRITE, OFF_CTRLB, 8'h00);
    endtask

    task automatic test_master_transfer();
        send_item(CMD_WRITE, OFF_INTCTRL, 8'h01);
        send_item(CMD_WRITE, OFF_CTRLA, make_ctrla(1'b1, 1'b1, 1'b0, 3'd4, 1'b1));
        send_item(CMD_WRITE, OFF_DATA, 8'hA5);
        send_item(CMD_WRITE, OFF_DATA, 8'h5A);
        // buffer already full: collision
        send_item(CMD_WRITE, OFF_DATA, 8'hFF);
        run_ticks(1'b0);
        send_item(CMD_READ, OFF_INTFLAGS, 8'h00);
        send_item(CMD_ACK, OFF_DATA, 8'h00);
        send_item(CMD_ACK, OFF_DATA, 8'h00);
        send_item(CMD_READ, OFF_DATA, 8'h00);
        send_item(CMD_WRITE, OFF_INTFLAGS, 8'h80);
    endtask

    task automatic test_cpol_and_slave();
        send_item(CMD_WRITE, OFF_CTRLA, make_ctrla(1'b0, 1'b1, 1'b1, 3'd0, 1'b0));
        send_item(CMD_WRITE, OFF_CTRLA, make_ctrla(1'b1, 1'b1, 1'b1, 3'd0, 1'b0));
        send_item(CMD_WRITE, OFF_DATA, 8'h3C);
        repeat (5) send_tick();
        // drop enable in the middle of a transfer
        send_item(CMD_WRITE, OFF_CTRLA, make_ctrla(1'b0, 1'b1, 1'b1, 3'd0, 1'b0));
        send_item(CMD_READ, OFF_INTFLAGS, 8'h00);
        send_item(CMD_WRITE, OFF_CTRLA, make_ctrla(1'b1, 1'b0, 1'b1, 3'd5, 1'b1));
        send_item(CMD_WRITE, OFF_DATA, 8'h00);
        run_ticks(1'b0);
        send_item(CMD_READ, OFF_DATA, 8'h00);
    endtask

    task automatic test_backpressure();
        idle_off     = 1'b1;
        hold_pending = 1'b1;
        // drop the last accepted item while waiting for the receiver to hold off
        i_s_axis_tvalid <= 1'b0;
        while (!hold_active) @(posedge i_clk);
        send_item(CMD_WRITE, OFF_CTRLA, make_ctrla(1'b1, 1'b1, 1'b0, 3'd4, 1'b1));
        send_item(CMD_WRITE, OFF_DATA, 8'h96);
        repeat (36) send_tick();
        send_item(CMD_READ, OFF_DATA, 8'h00);
        idle_off = 1'b0;
    endtask

    task automatic test_random_traffic(input int target);
        int first;
        int r;
        logic [7:0] v;
        first = items_sent;
        while (items_sent - first < target) begin
            idle_off = ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 8))
                    send_item(t_cmd'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                              8'($urandom));
            end else begin
                if (!ctrl_a[CA_ENABLE] || $urandom_range(0, 1) == 1) begin
                    v = 8'($urandom);
                    // mostly short transfers, now and then any divisor
                    if ($urandom_range(0, 99) < 80) begin
                        case ($urandom_range(0, 3))
                            0: v[3:1] = 3'd4;
                            1: v[3:1] = 3'd0;
                            2: v[3:1] = 3'd7;
                            default: v[3:1] = 3'd5;
                        endcase
                    end
                    v[CA_ENABLE] = ($urandom_range(0, 99) < 92);
                    v[CA_MASTER] = ($urandom_range(0, 99) < 85);
                    send_item(CMD_WRITE, OFF_CTRLA, v);
                end
                if ($urandom_range(0, 3) == 0)
                    send_item(CMD_WRITE, OFF_INTCTRL, 8'($urandom));
                if ($urandom_range(0, 7) == 0)
                    send_item(CMD_WRITE, OFF_CTRLB, 8'($urandom));
                repeat ($urandom_range(1, 3)) begin
                    send_item(CMD_WRITE, OFF_DATA, 8'($urandom));
                    if ($urandom_range(0, 3) == 0) send_tick();
                end
                run_ticks(1'b1);
                r = $urandom_range(0, 4);
                case (r)
                    0: send_item(CMD_READ, OFF_DATA, 8'($urandom));
                    1: send_item(CMD_READ, OFF_INTFLAGS, 8'($urandom));
                    2: send_item(CMD_ACK, 3'($urandom_range(0, 7)), 8'($urandom));
                    3: send_item(CMD_WRITE, OFF_INTFLAGS, 8'($urandom));
                    default: ;
                endcase
            end
        end
        idle_off = 1'b0;
    endtask

    // Receiver: random ready pattern, plus one long hold-off on request.
    initial begin
        int run;
        int gap;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_pending) begin
                hold_active = 1'b1;
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_active  = 1'b0;
                hold_pending = 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
                run = $urandom_range(1, 24);
                repeat (run) @(posedge i_clk);
                gap = idle_off ? 0 : pick_gap();
                if (gap > 0) begin
                    i_m_axis_tready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_result
        t_result got;
        t_result want;
        bit      bad;
        if (i_rst_n && o_m_axis_tvalid === 1'b1 && i_m_axis_tready) begin
            got = o_m_axis_tdata[13:0];
            if (expected_results.size() == 0) begin
                orphan_count++;
                $display("Unexpected result %h with nothing outstanding", o_m_axis_tdata);
            end else begin
                want = expected_results.pop_front();
                bad = (got.read_value !== want.read_value) || (got.irq !== want.irq) ||
                      (got.ack !== want.ack) || (got.mosi !== want.mosi) ||
                      (got.sck !== want.sck) || (got.ss !== want.ss) ||
                      (got.drive !== want.drive);
                if (bad) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"Result %0d mismatch (exp/act): read %h/%h irq %b/%b ",
                                  "ack %b/%b mosi %b/%b sck %b/%b ss %b/%b drive %b/%b"},
                                 results_checked, want.read_value, got.read_value,
                                 want.irq, got.irq, want.ack, got.ack, want.mosi, got.mosi,
                                 want.sck, got.sck, want.ss, got.ss, want.drive, got.drive);
                end
            end
            results_checked++;
        end
    end

    initial begin
        int waited;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_register_access();
        test_master_transfer();
        test_cpol_and_slave();
        test_backpressure();
        test_random_traffic(RANDOM_ITEMS);
        i_s_axis_tvalid <= 1'b0;
        waited = 0;
        while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0)
            $display("%0d expected results never arrived", expected_results.size());
        $display("Sent %0d items and checked %0d results, %0d of them mismatching",
                 items_sent, results_checked, mismatch_count);
        $display("Predicted %0d completed SPI transfers and %0d write collisions",
                 transfers_done, collisions);
        if (mismatch_count == 0 && orphan_count == 0 && expected_results.size() == 0) begin
            $display("tb_spi_master_peripheral passed");
        end else begin
            $display("tb_spi_master_peripheral failed");
        end
        $finish;
    end

endmodule
